/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros for the report ring
// concurrent checks clocked on clk, held off while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define RRF_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("rrf assertion failed");

// condition must never be true at a clock edge out of reset
`define RRF_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("rrf forbidden condition seen");

`else

`define RRF_ASSERT(lbl, prop)
`define RRF_NEVER(lbl, cond)

`endif

`endif

/* rtl/rrf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrf_pkg
// shared constants, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package rrf_pkg;

	// ring geometry
	localparam int RING_BYTES = 8192;
	localparam int PTR_W      = $clog2(RING_BYTES);
	localparam int CNT_W      = $clog2(RING_BYTES + 1);

	// request codes
	localparam logic [1:0] FUNC_BEGIN = 2'd0;
	localparam logic [1:0] FUNC_DATA  = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;
	localparam logic [1:0] FUNC_CLEAR = 2'd3;

	// result status codes
	localparam logic [2:0] STAT_OK         = 3'd0;
	localparam logic [2:0] STAT_EMPTY      = 3'd1;
	localparam logic [2:0] STAT_BAD_LEN    = 3'd2;
	localparam logic [2:0] STAT_NO_OPEN    = 3'd3;
	localparam logic [2:0] STAT_UNFINISHED = 3'd4;

	// amount released at the read side
	localparam logic [1:0] CONS_NONE = 2'd0;
	localparam logic [1:0] CONS_ONE  = 2'd1;
	localparam logic [1:0] CONS_PART = 2'd2;
	localparam logic [1:0] CONS_HDR  = 2'd3;

	// update of the bytes left in the report being read
	localparam logic [1:0] RBL_HOLD = 2'd0;
	localparam logic [1:0] RBL_ZERO = 2'd1;
	localparam logic [1:0] RBL_PART = 2'd2;
	localparam logic [1:0] RBL_HDR  = 2'd3;

	// controller to datapath commands
	typedef struct packed {
		logic       load_in;
		logic       clear;
		logic       wr_en;
		logic       wr_hdr;
		logic [1:0] cons;
		logic [1:0] rbl_op;
		logic       res_load;
		logic [2:0] res_status;
		logic       set_drop;
		logic       cap_byte;
		logic       push;
	} rrf_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic [1:0] func;
		logic       len_zero;
		logic       wbl_zero;
		logic       fits;
		logic       comm_zero;
		logic       used_zero;
		logic       rbl_zero;
		logic       part_zero;
		logic       hdr_zero;
	} rrf_stat_t;

endpackage

/* rtl/rrf_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrf_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module rrf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* rtl/rrf_ctrl.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// rrf_ctrl
// request sequencer: decodes a request, walks dropped headers, hands results out
// ----------------------------------------------------------------------------
module rrf_ctrl import rrf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  rrf_stat_t stat,
	output rrf_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_CHECK = 3'd2;
	localparam logic [2:0] S_HDR   = 3'd3;
	localparam logic [2:0] S_RHDR  = 3'd4;
	localparam logic [2:0] S_RBYTE = 3'd5;
	localparam logic [2:0] S_FIN   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       push;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign push      = (state_q == S_FIN) && (!out_valid_q || out_ready);

	// next state and command decode
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_FIN;
				case (stat.func)
					FUNC_BEGIN: begin
						if (stat.len_zero) begin
							cmd.res_load   = 1'b1;
							cmd.res_status = STAT_BAD_LEN;
						end else if (!stat.wbl_zero) begin
							cmd.res_load   = 1'b1;
							cmd.res_status = STAT_UNFINISHED;
						end else begin
							// discard the unread rest of a partly read report first
							if (!stat.fits && !stat.rbl_zero) begin
								cmd.cons     = CONS_PART;
								cmd.rbl_op   = RBL_ZERO;
								cmd.set_drop = 1'b1;
							end
							state_d = S_CHECK;
						end
					end
					FUNC_DATA: begin
						if (stat.wbl_zero) begin
							cmd.res_load   = 1'b1;
							cmd.res_status = STAT_NO_OPEN;
						end else begin
							cmd.wr_en = 1'b1;
						end
					end
					FUNC_READ: begin
						if (stat.rbl_zero) begin
							if (stat.comm_zero) begin
								cmd.res_load   = 1'b1;
								cmd.res_status = stat.used_zero ? STAT_EMPTY
								                                : STAT_UNFINISHED;
							end else begin
								// header goes out of the ram, next state sees it
								cmd.cons = CONS_ONE;
								state_d  = S_RHDR;
							end
						end else if (stat.part_zero) begin
							cmd.rbl_op     = RBL_ZERO;
							cmd.res_load   = 1'b1;
							cmd.res_status = STAT_EMPTY;
						end else begin
							cmd.cons   = CONS_ONE;
							cmd.rbl_op = RBL_PART;
							state_d    = S_RBYTE;
						end
					end
					FUNC_CLEAR: begin
						cmd.clear = 1'b1;
					end
					default: begin
						cmd.clear = 1'b1;
					end
				endcase
			end
			S_CHECK: begin
				if (!stat.fits && !stat.comm_zero) begin
					// drop the oldest whole report: header first
					cmd.cons     = CONS_ONE;
					cmd.set_drop = 1'b1;
					state_d      = S_HDR;
				end else begin
					if (stat.fits) begin
						cmd.wr_en  = 1'b1;
						cmd.wr_hdr = 1'b1;
					end
					state_d = S_FIN;
				end
			end
			S_HDR: begin
				// skip the dropped report body
				cmd.cons = CONS_HDR;
				state_d  = S_CHECK;
			end
			S_RHDR: begin
				if (stat.hdr_zero) begin
					cmd.rbl_op     = RBL_ZERO;
					cmd.res_load   = 1'b1;
					cmd.res_status = STAT_EMPTY;
					state_d        = S_FIN;
				end else begin
					cmd.cons   = CONS_ONE;
					cmd.rbl_op = RBL_HDR;
					state_d    = S_RBYTE;
				end
			end
			S_RBYTE: begin
				cmd.cap_byte = 1'b1;
				state_d      = S_FIN;
			end
			S_FIN: begin
				if (push) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		cmd.push = push;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// checks
	`RRF_ASSERT(a_accept_to_exec, (in_valid && in_ready) |=> (state_q == S_EXEC))
	`RRF_ASSERT(a_hdr_to_check, (state_q == S_HDR) |=> (state_q == S_CHECK))
	`RRF_ASSERT(a_fin_holds, (state_q == S_FIN && out_valid_q && !out_ready) |=> (state_q == S_FIN))

endmodule

/* rtl/rrf_dp.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// rrf_dp
// ring datapath: byte store, pointers, counters, result and output registers
// ----------------------------------------------------------------------------
module rrf_dp import rrf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] func,
	input  logic [7:0] data_byte,
	input  logic [7:0] report_length,
	input  rrf_cmd_t   cmd,
	output rrf_stat_t  stat,
	output logic [2:0] status,
	output logic [7:0] read_byte,
	output logic       read_last,
	output logic       dropped_any
);

	localparam logic [PTR_W:0]   RING_P = (PTR_W + 1)'(RING_BYTES);
	localparam logic [CNT_W-1:0] RING_C = CNT_W'(RING_BYTES);

	// latched request
	logic [1:0]       func_q;
	logic [7:0]       data_q;
	logic [7:0]       len_q;

	// ring state
	logic [PTR_W-1:0] rp_q;
	logic [PTR_W-1:0] wp_q;
	logic [CNT_W-1:0] used_q;
	logic [CNT_W-1:0] comm_q;
	logic [7:0]       wbl_q;
	logic [7:0]       rbl_q;

	// working result and output registers
	logic [2:0]       res_status_q;
	logic [7:0]       res_byte_q;
	logic             res_last_q;
	logic             res_drop_q;
	logic [2:0]       out_status_q;
	logic [7:0]       out_byte_q;
	logic             out_last_q;
	logic             out_drop_q;

	logic [7:0]       rd_data;
	logic [7:0]       wr_data;
	logic [CNT_W-1:0] free_bytes;
	logic [CNT_W-1:0] need_bytes;
	logic [7:0]       part;
	logic [7:0]       hdr_clamp;
	logic [7:0]       cons_amt;
	logic [PTR_W:0]   rp_sum;
	logic [PTR_W:0]   wp_sum;
	logic [PTR_W-1:0] rp_next;
	logic [PTR_W-1:0] wp_next;
	logic             commit;

	// byte store
	assign wr_data = cmd.wr_hdr ? len_q : data_q;

	rrf_ram #(
		.WIDTH (8),
		.DEPTH (RING_BYTES)
	) u_ram (
		.clk   (clk),
		.we    (cmd.wr_en),
		.waddr (wp_q),
		.wdata (wr_data),
		.raddr (rp_q),
		.rdata (rd_data)
	);

	// room check and clamps against the completed bytes
	assign free_bytes = RING_C - used_q;
	assign need_bytes = CNT_W'(len_q) + CNT_W'(1);
	assign part       = (CNT_W'(rbl_q) > comm_q) ? comm_q[7:0] : rbl_q;
	assign hdr_clamp  = (CNT_W'(rd_data) > comm_q) ? comm_q[7:0] : rd_data;

	// bytes released at the read side
	always_comb begin
		case (cmd.cons)
			CONS_NONE: cons_amt = 8'd0;
			CONS_ONE:  cons_amt = 8'd1;
			CONS_PART: cons_amt = part;
			CONS_HDR:  cons_amt = hdr_clamp;
			default:   cons_amt = 8'd0;
		endcase
	end

	// pointer wrap
	assign rp_sum  = {1'b0, rp_q} + (PTR_W + 1)'(cons_amt);
	assign wp_sum  = {1'b0, wp_q} + (PTR_W + 1)'(1);
	assign rp_next = (rp_sum >= RING_P) ? PTR_W'(rp_sum - RING_P) : rp_sum[PTR_W-1:0];
	assign wp_next = (wp_sum >= RING_P) ? PTR_W'(wp_sum - RING_P) : wp_sum[PTR_W-1:0];

	// last data byte of the open report completes it
	assign commit = cmd.wr_en && !cmd.wr_hdr && (wbl_q == 8'd1);

	// status to the controller
	assign stat.func      = func_q;
	assign stat.len_zero  = (len_q == 8'd0);
	assign stat.wbl_zero  = (wbl_q == 8'd0);
	assign stat.fits      = (free_bytes >= need_bytes);
	assign stat.comm_zero = (comm_q == '0);
	assign stat.used_zero = (used_q == '0);
	assign stat.rbl_zero  = (rbl_q == 8'd0);
	assign stat.part_zero = (part == 8'd0);
	assign stat.hdr_zero  = (hdr_clamp == 8'd0);

	// request latch
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			func_q <= func;
			data_q <= data_byte;
			len_q  <= report_length;
		end
	end

	// pointers and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q   <= '0;
			wp_q   <= '0;
			used_q <= '0;
			comm_q <= '0;
			wbl_q  <= '0;
			rbl_q  <= '0;
		end else if (cmd.clear) begin
			rp_q   <= '0;
			wp_q   <= '0;
			used_q <= '0;
			comm_q <= '0;
			wbl_q  <= '0;
			rbl_q  <= '0;
		end else begin
			rp_q   <= rp_next;
			used_q <= used_q - CNT_W'(cons_amt) + CNT_W'(cmd.wr_en);
			if (commit) begin
				comm_q <= used_q + CNT_W'(1);
			end else begin
				comm_q <= comm_q - CNT_W'(cons_amt);
			end
			if (cmd.wr_en) begin
				wp_q  <= wp_next;
				wbl_q <= cmd.wr_hdr ? len_q : wbl_q - 8'd1;
			end
			case (cmd.rbl_op)
				RBL_HOLD: rbl_q <= rbl_q;
				RBL_ZERO: rbl_q <= 8'd0;
				RBL_PART: rbl_q <= part - 8'd1;
				RBL_HDR:  rbl_q <= hdr_clamp - 8'd1;
				default:  rbl_q <= rbl_q;
			endcase
		end
	end

	// working result
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			res_status_q <= STAT_OK;
			res_byte_q   <= 8'd0;
			res_last_q   <= 1'b0;
			res_drop_q   <= 1'b0;
		end else begin
			if (cmd.res_load) begin
				res_status_q <= cmd.res_status;
			end
			if (cmd.set_drop) begin
				res_drop_q <= 1'b1;
			end
			if (cmd.rbl_op == RBL_PART) begin
				res_last_q <= (part == 8'd1);
			end else if (cmd.rbl_op == RBL_HDR) begin
				res_last_q <= (hdr_clamp == 8'd1);
			end
			if (cmd.cap_byte) begin
				res_byte_q <= rd_data;
			end
		end
	end

	// output register, loaded when the result is handed over
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_status_q <= res_status_q;
			out_byte_q   <= res_byte_q;
			out_last_q   <= res_last_q;
			out_drop_q   <= res_drop_q;
		end
	end

	assign status      = out_status_q;
	assign read_byte   = out_byte_q;
	assign read_last   = out_last_q;
	assign dropped_any = out_drop_q;

	// checks
	`RRF_NEVER(a_comm_le_used, comm_q > used_q)
	`RRF_NEVER(a_used_le_ring, used_q > RING_C)
	`RRF_ASSERT(a_closed_all_committed, (wbl_q == 8'd0) |-> (used_q == comm_q))

endmodule

/* rtl/report_ring_fifo_drop_oldest.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// report_ring_fifo_drop_oldest
// byte ring of length-prefixed reports with drop-oldest on overflow
// ----------------------------------------------------------------------------
// Every request returns exactly one result. The block takes one request at a
// time. The first read of a report fetches the header and then the byte, each
// through the registered read port of the 8192-byte ring memory; a read in the
// middle of a report fetches only the byte. A begin that must make room reads
// the header of each dropped report, then skips its body. A new request is
// taken while the previous result still waits in the output register. The
// ring memory is not cleared after reset or by a clear request; only
// completed reports are ever read.
module report_ring_fifo_drop_oldest import rrf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] func,
	input  logic [7:0] data_byte,
	input  logic [7:0] report_length,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] status,
	output logic [7:0] read_byte,
	output logic       read_last,
	output logic       dropped_any
);

	rrf_cmd_t  cmd;
	rrf_stat_t stat;

	// request sequencer
	rrf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// ring datapath
	rrf_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.func          (func),
		.data_byte     (data_byte),
		.report_length (report_length),
		.cmd           (cmd),
		.stat          (stat),
		.status        (status),
		.read_byte     (read_byte),
		.read_last     (read_last),
		.dropped_any   (dropped_any)
	);

endmodule
